/* hw/rtl/bawc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawc_pkg: shared definitions for the bit-sliced add-with-carry generator
// Opcodes, configuration register indexes, field widths and the lane
// control bundle.
// ----------------------------------------------------------------------------
package bawc_pkg;

  // Field widths
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned LONG_LAG_W  = 9;
  localparam int unsigned SHORT_LAG_W = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  // Opcodes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LAG  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LAG = 1'b1;

  // Register reset values
  localparam logic [LONG_LAG_W-1:0]  LONG_LAG_RST  = 9'd64;
  localparam logic [SHORT_LAG_W-1:0] SHORT_LAG_RST = 8'd37;

  // Control shared by all lanes
  typedef struct packed {
    logic step;     // take one generate step
    logic restart;  // seed: set carry to one
  } lane_ctl_t;

endpackage

/* hw/rtl/bawc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawc_ram: generic RAM, one write port, two registered read ports
// Read data reflects memory contents before a same-cycle write.
// ----------------------------------------------------------------------------
module bawc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* hw/rtl/bawc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawc_lane: one base-2 add-with-carry generator lane
// Sum of short tap, long tap and carry; carry takes the majority.
// ----------------------------------------------------------------------------
module bawc_lane import bawc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  logic      a_i,
  input  logic      b_i,
  output logic      sum_o
);

  logic carry_q;
  logic carry_d;

  // Full-adder sum
  assign sum_o = a_i ^ b_i ^ carry_q;

  // Restart to one on seed, take majority on a step
  always_comb begin
    carry_d = carry_q;
    if (ctl_i.restart) begin
      carry_d = 1'b1;
    end else if (ctl_i.step) begin
      carry_d = (a_i & b_i) | (a_i & carry_q) | (b_i & carry_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b1;
    end else begin
      carry_q <= carry_d;
    end
  end

endmodule

/* hw/rtl/bitsliced_add_with_carry_rng_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitsliced_add_with_carry_rng_core: 64 bit-sliced add-with-carry generators
// A generate beat is registered in the second stage, then in the output register.
// Throughput: one beat per cycle while the output is not stalled; two ring reads
// and one ring write per cycle, with a bypass of the ring write of the read cycle.
// Reset: carry all ones, long pointer 0, short pointer 27 for default lags,
// lag registers 64 and 37; the lag ring is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module bitsliced_add_with_carry_rng_core import bawc_pkg::*; #(
  parameter int unsigned MAX_LAG = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic [IDX_W-1:0]       seed_index_i,
  input  logic [WORD_W-1:0]      seed_word_i,
  // Output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WORD_W-1:0]      random_word_o
);

  localparam int unsigned PTR_W = $clog2(MAX_LAG);
  localparam int unsigned CW    = ($clog2(MAX_LAG + 1) > LONG_LAG_W) ?
                                  $clog2(MAX_LAG + 1) : LONG_LAG_W;
  localparam int unsigned RST_R = (MAX_LAG < 64) ? MAX_LAG : 64;
  localparam int unsigned RST_S = (RST_R - 1 < 37) ? RST_R - 1 : 37;
  localparam logic [PTR_W-1:0] SHORT_PTR_RST = PTR_W'(RST_R - RST_S);

  // Configuration registers
  logic [LONG_LAG_W-1:0]  long_lag_q;
  logic [SHORT_LAG_W-1:0] short_lag_q;

  // Ring pointers
  logic [PTR_W-1:0] long_ptr_q, long_ptr_d;
  logic [PTR_W-1:0] short_ptr_q, short_ptr_d;

  // Effective lags and pointer arithmetic
  logic [CW-1:0]    lag_l, lag_s, eff_r, eff_s;
  logic [CW-1:0]    long_inc, short_inc;
  logic [PTR_W-1:0] long_n, short_n;
  logic             seed_ok;

  // Second stage
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [PTR_W-1:0]  s1_long_q;
  logic [PTR_W-1:0]  s1_short_q;
  logic              s1_seed_we_q;
  logic [WORD_W-1:0] s1_seed_word_q;
  logic              s1_fire;

  // Bypass of the write that raced the ring read
  logic              byp_en_q;
  logic [PTR_W-1:0]  byp_addr_q;
  logic [WORD_W-1:0] byp_data_q;

  // Ring ports
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_short, rd_long;

  // Lane datapath
  logic [WORD_W-1:0] tap_a, tap_b, new_word;
  lane_ctl_t         lane_ctl;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;

  logic in_fire;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_lag_q  <= LONG_LAG_RST;
      short_lag_q <= SHORT_LAG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_LAG:  long_lag_q  <= cfg_data_i;
        CFG_SHORT_LAG: short_lag_q <= cfg_data_i[SHORT_LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp lags, normalize and advance pointers
  always_comb begin
    lag_l = CW'(long_lag_q);
    if (lag_l < CW'(2)) begin
      eff_r = CW'(2);
    end else if (lag_l > CW'(MAX_LAG)) begin
      eff_r = CW'(MAX_LAG);
    end else begin
      eff_r = lag_l;
    end

    lag_s = CW'(short_lag_q);
    if (lag_s < CW'(1)) begin
      eff_s = CW'(1);
    end else if (lag_s > eff_r - CW'(1)) begin
      eff_s = eff_r - CW'(1);
    end else begin
      eff_s = lag_s;
    end

    long_n  = (CW'(long_ptr_q) >= eff_r) ? '0 : long_ptr_q;
    short_n = (CW'(short_ptr_q) >= eff_r) ? '0 : short_ptr_q;
    long_inc  = CW'(long_n) + CW'(1);
    short_inc = CW'(short_n) + CW'(1);
    seed_ok   = CW'(seed_index_i) < eff_r;
  end

  // Accept a beat whenever the second stage can move on
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && ((s1_op_q == OP_SEED) || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;

  // Next pointers: restart on seed, step on generate
  always_comb begin
    long_ptr_d  = long_ptr_q;
    short_ptr_d = short_ptr_q;
    if (in_fire) begin
      if (opcode_i == OP_SEED) begin
        long_ptr_d  = '0;
        short_ptr_d = PTR_W'(eff_r - eff_s);
      end else begin
        long_ptr_d  = (long_inc >= eff_r) ? '0 : PTR_W'(long_inc);
        short_ptr_d = (short_inc >= eff_r) ? '0 : PTR_W'(short_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ptr_q  <= '0;
      short_ptr_q <= SHORT_PTR_RST;
    end else begin
      long_ptr_q  <= long_ptr_d;
      short_ptr_q <= short_ptr_d;
    end
  end

  // Second stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_en_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        byp_en_q   <= ram_we;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Second stage payload; a seed keeps its write address in the long slot
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q        <= opcode_i;
      s1_long_q      <= (opcode_i == OP_SEED) ? PTR_W'(seed_index_i) : long_n;
      s1_short_q     <= short_n;
      s1_seed_we_q   <= seed_ok;
      s1_seed_word_q <= seed_word_i;
      byp_addr_q     <= ram_waddr;
      byp_data_q     <= ram_wdata;
    end
  end

  // Lag ring
  assign ram_we    = s1_fire && ((s1_op_q == OP_GEN) || s1_seed_we_q);
  assign ram_waddr = s1_long_q;
  assign ram_wdata = (s1_op_q == OP_GEN) ? new_word : s1_seed_word_q;

  bawc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_LAG)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (in_fire),
    .raddr_a_i (short_n),
    .raddr_b_i (long_n),
    .rdata_a_o (rd_short),
    .rdata_b_o (rd_long)
  );

  // Forward the write that landed in the read cycle
  assign tap_a = (byp_en_q && (byp_addr_q == s1_short_q)) ? byp_data_q : rd_short;
  assign tap_b = (byp_en_q && (byp_addr_q == s1_long_q))  ? byp_data_q : rd_long;

  assign lane_ctl.step    = s1_fire && (s1_op_q == OP_GEN);
  assign lane_ctl.restart = s1_fire && (s1_op_q == OP_SEED);

  // One generator per bit lane
  for (genvar g = 0; g < WORD_W; g++) begin : g_lane
    bawc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .a_i    (tap_a[g]),
      .b_i    (tap_b[g]),
      .sum_o  (new_word[g])
    );
  end

  // Merge lane bits into the output beat; hold while stalled
  always_comb begin
    out_valid_d = out_valid_q;
    if (lane_ctl.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ctl.step) begin
      out_word_q <= new_word;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

endmodule

/* hw/rtl/bawc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawc_checker: port-level checks for the add-with-carry generator
// Watches handshakes and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module bawc_checker import bawc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              opcode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [WORD_W-1:0] random_word_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(random_word_o))
    else $error("stalled result beat changed");

  // Stall the input only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted generate beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && (opcode_i == OP_GEN), 2)
      || $past(out_valid_o && !out_stall_i))
    else $error("result beat without a generate beat");

endmodule

bind bitsliced_add_with_carry_rng_core bawc_checker u_bawc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .opcode_i      (opcode_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .random_word_o (random_word_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bit-sliced add-with-carry generator
// Sends seed loads and generate beats with random gaps and random output
// stalls. A local mirror of the lag ring, the carry lanes and both pointers
// predicts every random_word, and each output beat is compared in order.
// The lag registers sweep through extremes, clamped values and random
// settings between phases, and some phases start without a reseed.
// ----------------------------------------------------------------------------
module tb_top import bawc_pkg::*; ();

  localparam int unsigned RING_DEPTH   = 256;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned NUM_FIXED    = 9;
  localparam int unsigned NUM_DIR      = 19;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // One directed beat; result is only used where typed is set
  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [WORD_W-1:0] result;
  } dir_row_t;

  // Default lags: long pointer 0, short pointer 27 after every load
  localparam dir_row_t DIR_TBL [NUM_DIR] = '{
    '{OP_SEED, 8'd0,   64'h0,                  1'b0, 64'h0},
    '{OP_SEED, 8'd27,  64'h0,                  1'b0, 64'h0},
    '{OP_GEN,  8'd0,   64'h0,                  1'b1, ALL_ONES},  // only carry set
    '{OP_SEED, 8'd0,   ALL_ONES,               1'b0, 64'h0},
    '{OP_SEED, 8'd27,  ALL_ONES,               1'b0, 64'h0},
    '{OP_GEN,  8'hFF,  ALL_ONES,               1'b1, ALL_ONES},  // all three set
    '{OP_SEED, 8'd27,  64'h0,                  1'b0, 64'h0},
    '{OP_GEN,  8'd0,   64'h0,                  1'b1, 64'h0},     // long and carry set
    '{OP_SEED, 8'd255, 64'h5555_5555_5555_5555, 1'b0, 64'h0},    // index past ring
    '{OP_GEN,  8'h80,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ALL_ONES},
    '{OP_SEED, 8'd1,   64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 64'h0},
    '{OP_SEED, 8'd28,  64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
    '{OP_SEED, 8'd64,  ALL_ONES,               1'b0, 64'h0},     // first index past ring
    '{OP_GEN,  8'd0,   64'h0,                  1'b1, 64'h0},
    '{OP_GEN,  8'd0,   64'h0,                  1'b0, 64'h0},
    '{OP_SEED, 8'd63,  64'h8000_0000_0000_0001, 1'b0, 64'h0},    // last ring index
    '{OP_SEED, 8'd36,  64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
    '{OP_GEN,  8'd0,   64'h0,                  1'b1, ALL_ONES},
    '{OP_GEN,  8'd0,   64'h0,                  1'b0, 64'h0}
  };

  // Lag settings: saturation, clamping, dropped upper bit of short lag
  localparam logic [CFG_DATA_W-1:0] FIXED_LONG [NUM_FIXED] = '{
    9'd511, 9'd256, 9'd2, 9'd0, 9'd17, 9'd64, 9'd3, 9'd255, 9'd300
  };
  localparam logic [CFG_DATA_W-1:0] FIXED_SHORT [NUM_FIXED] = '{
    9'h1FF, 9'd1, 9'd1, 9'd0, 9'd200, 9'd37, 9'h100, 9'd254, 9'd128
  };

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_LONG_LAG;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  opcode_i      = OP_SEED;
  logic [IDX_W-1:0]      seed_index_i  = '0;
  logic [WORD_W-1:0]     seed_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [WORD_W-1:0]     random_word_o;

  // Generator mirror
  logic [WORD_W-1:0]      ring_mirror [RING_DEPTH];
  bit                     entry_set   [RING_DEPTH];
  logic [WORD_W-1:0]      carry_lanes;
  int unsigned            long_ptr;
  int unsigned            short_ptr;
  logic [LONG_LAG_W-1:0]  long_lag_reg  = LONG_LAG_RST;
  logic [SHORT_LAG_W-1:0] short_lag_reg = SHORT_LAG_RST;

  logic [WORD_W-1:0] pending_words [$];
  bit                burst_mode = 1'b0;
  int unsigned       err_count  = 0;
  int unsigned       n_loads    = 0;
  int unsigned       n_gens     = 0;
  int unsigned       n_checked  = 0;

  bitsliced_add_with_carry_rng_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .seed_index_i  (seed_index_i),
    .seed_word_i   (seed_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("tb_top: %0t mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Effective ring length: long lag held to 2..RING_DEPTH
  function automatic int unsigned ring_len();
    int unsigned r;
    r = 32'(long_lag_reg);
    if (r < 2) r = 2;
    if (r > RING_DEPTH) r = RING_DEPTH;
    return r;
  endfunction

  // Effective short lag: held to 1..r-1
  function automatic int unsigned tap_distance(input int unsigned r);
    int unsigned s;
    s = 32'(short_lag_reg);
    if (s < 1) s = 1;
    if (s > r - 1) s = r - 1;
    return s;
  endfunction

  function automatic void restart_mirror();
    int unsigned r;
    r = ring_len();
    carry_lanes = ALL_ONES;
    long_ptr    = 0;
    short_ptr   = r - tap_distance(r);
  endfunction

  // Ring entry that the next generate would read before it was ever set, else -1
  function automatic int unset_read();
    int unsigned r, lp, sp;
    r  = ring_len();
    lp = (long_ptr >= r) ? 0 : long_ptr;
    sp = (short_ptr >= r) ? 0 : short_ptr;
    if (!entry_set[sp]) return int'(sp);
    if (!entry_set[lp]) return int'(lp);
    return -1;
  endfunction

  // Advance the mirror by one accepted beat and queue the word it yields
  function automatic void advance_mirror(input logic op, input logic [IDX_W-1:0] idx,
                                         input logic [WORD_W-1:0] word, input logic typed,
                                         input logic [WORD_W-1:0] typed_word);
    int unsigned r;
    logic [WORD_W-1:0] a, b, c, w;
    r = ring_len();
    if (op == OP_SEED) begin
      if (idx < r) begin
        ring_mirror[idx] = word;
        entry_set[idx]   = 1'b1;
      end
      restart_mirror();
      n_loads++;
    end else begin
      if (long_ptr >= r) long_ptr = 0;
      if (short_ptr >= r) short_ptr = 0;
      a = ring_mirror[short_ptr];
      b = ring_mirror[long_ptr];
      c = carry_lanes;
      w = a ^ b ^ c;
      carry_lanes = (c | a) & (c | b) & (a | b);
      ring_mirror[long_ptr] = w;
      long_ptr  = (long_ptr + 1 >= r) ? 0 : long_ptr + 1;
      short_ptr = (short_ptr + 1 >= r) ? 0 : short_ptr + 1;
      pending_words.push_back(typed ? typed_word : w);
      n_gens++;
    end
  endfunction

  // Idle a random number of cycles, then hold the beat until it is taken
  task automatic apply_beat(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] word, input logic typed,
                            input logic [WORD_W-1:0] typed_word);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    seed_index_i <= idx;
    seed_word_i  <= word;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    advance_mirror(op, idx, word, typed, typed_word);
  endtask

  // Write both lag registers, one per edge
  task automatic program_lags(input logic [CFG_DATA_W-1:0] long_val,
                              input logic [CFG_DATA_W-1:0] short_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LONG_LAG;
    cfg_data_i <= long_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SHORT_LAG;
    cfg_data_i <= short_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    long_lag_reg  = long_val[LONG_LAG_W-1:0];
    short_lag_reg = short_val[SHORT_LAG_W-1:0];
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected word is out and the pipe is quiet
  task automatic drain_outputs();
    int unsigned spins;
    in_valid_i <= 1'b0;
    spins = 0;
    while (pending_words.size() != 0 && spins < 4000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Output stall: draw a hold time for every output beat
  initial begin : out_stall_gen
    int unsigned n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = burst_mode ? 0 : $urandom_range(0, 15);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  // Compare each output beat with the oldest expected word
  always @(posedge clk_i) begin : check_words
    logic [WORD_W-1:0] want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected random_word %h", random_word_o));
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (random_word_o !== want) begin
          report_mismatch($sformatf("random_word %h, expected %h", random_word_o, want));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned r, n_items, roll, burst_len;
    int miss;
    logic [CFG_DATA_W-1:0] lv, sv;
    for (int i = 0; i < RING_DEPTH; i++) begin
      entry_set[i]   = 1'b0;
      ring_mirror[i] = '0;
    end
    restart_mirror();

    // Hold reset low, then release it
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset lags
    for (int i = 0; i < NUM_DIR; i++) begin
      apply_beat(DIR_TBL[i].op, DIR_TBL[i].idx, DIR_TBL[i].word,
                 DIR_TBL[i].typed, DIR_TBL[i].result);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_outputs();
      if (ph < NUM_FIXED) begin
        lv = FIXED_LONG[ph];
        sv = FIXED_SHORT[ph];
      end else begin
        lv = CFG_DATA_W'($urandom_range(0, 511));
        sv = CFG_DATA_W'($urandom_range(0, 511));
      end
      program_lags(lv, sv);
      burst_mode = ($urandom_range(0, 3) == 0);
      r = ring_len();

      // First phase fills the whole ring; later fixed phases keep the old
      // pointers so a shorter ring starts with pointers past its end
      if (ph == 0) begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          apply_beat(OP_SEED, IDX_W'(i), rand_word(), 1'b0, '0);
        end
      end else if (ph >= NUM_FIXED && $urandom_range(0, 1) == 1) begin
        apply_beat(OP_SEED, IDX_W'($urandom_range(0, r - 1)), rand_word(), 1'b0, '0);
      end

      n_items = (ph == 0) ? 120 : $urandom_range(80, 120);
      for (int k = 0; k < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          miss = unset_read();
          if (miss < 0) begin
            apply_beat(OP_GEN, IDX_W'($urandom), rand_word(), 1'b0, '0);
          end else begin
            apply_beat(OP_SEED, IDX_W'(miss), rand_word(), 1'b0, '0);
          end
        end else if (roll < 95) begin
          // Reseed a few entries inside the ring
          burst_len = $urandom_range(1, 4);
          for (int j = 0; j < burst_len; j++) begin
            apply_beat(OP_SEED, IDX_W'($urandom_range(0, r - 1)), rand_word(), 1'b0, '0);
          end
        end else begin
          apply_beat(OP_SEED, IDX_W'($urandom), rand_word(), 1'b0, '0);
        end
      end
    end

    drain_outputs();
    if (pending_words.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never came out", pending_words.size()));
    end
    $display("tb_top: covered %0d seed loads and %0d generate beats over %0d lag settings",
             n_loads, n_gens, NUM_PHASES + 1);
    $display("tb_top: %0d words compared, %0d mismatches", n_checked, err_count);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
